// ===== hw/rtl/viewport_scissor_guardband_defines.svh =====
// assertion macros for the viewport scissor and guard band block
`ifndef VIEWPORT_SCISSOR_GUARDBAND_DEFINES_SVH
`define VIEWPORT_SCISSOR_GUARDBAND_DEFINES_SVH

// same-cycle implication
`define VSG_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication
`define VSG_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== hw/rtl/vsg_pkg.sv =====
// shared types, constants and helpers for the viewport scissor and guard band block
package vsg_pkg;

  localparam int FRAC_BITS = 8;
  localparam int VW = 26;
  localparam int DW = 27;
  localparam int RW = DW + 1;
  localparam int QW = 32;
  localparam int DIV_BITS = 4;
  localparam int DIV_STAGES = QW / DIV_BITS;

  localparam logic [1:0] GEN_OLD = 2'd0;
  localparam logic [1:0] GEN_SECOND = 2'd1;
  localparam logic [1:0] GEN_THIRD = 2'd2;

  localparam logic [1:0] REG_GEN = 2'd0;
  localparam logic [1:0] REG_BYPASS = 2'd1;
  localparam logic [1:0] REG_DISCARD = 2'd2;

  localparam logic [15:0] MAXS_OLD = 16'd8192;
  localparam logic [15:0] MAXS_NEW = 16'd16384;
  localparam logic [16:0] TWO_R_OLD = 17'd32766;
  localparam logic [16:0] TWO_R_NEW = 17'd65534;

  localparam logic signed [VW-1:0] ONE = VW'(1 << FRAC_BITS);

  typedef struct packed {
    logic [1:0]  gen;
    logic        bypass;
    logic [23:0] disc;
  } cfg_t;

  typedef struct packed {
    logic [31:0] tl;
    logic [30:0] br;
  } side_t;

  typedef struct packed {
    logic [DW-1:0] wx;
    logic [DW-1:0] wy;
    logic [RW-1:0] rgx;
    logic [RW-1:0] rgy;
    logic [RW-1:0] rdx;
    logic [RW-1:0] rdy;
    logic [QW-1:0] qgx;
    logic [QW-1:0] qgy;
    logic [QW-1:0] qdx;
    logic [QW-1:0] qdy;
    side_t         side;
  } div_t;

  function automatic logic signed [VW-1:0] trunc_q(input logic signed [VW-1:0] v);
    logic [VW-1:0] mag;
    mag = v[VW-1] ? VW'(-v) : v;
    mag = mag >> FRAC_BITS;
    return v[VW-1] ? -signed'(mag) : signed'(mag);
  endfunction

  function automatic logic signed [VW-1:0] ceil_q(input logic signed [VW-1:0] v);
    logic [VW-1:0] mag;
    if (v[VW-1]) begin
      mag = VW'(-v);
      mag = mag >> FRAC_BITS;
      return -signed'(mag);
    end
    mag = (v + ONE - VW'(1)) >> FRAC_BITS;
    return signed'(mag);
  endfunction

endpackage

// ===== hw/rtl/vsg_front.sv =====
// front stages: corners, rounding, scissor, packing and divider setup
module vsg_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [23:0]    scale_x,
  input  logic [23:0]    scale_y,
  input  logic [23:0]    translate_x,
  input  logic [23:0]    translate_y,
  input  logic [14:0]    user_min_x,
  input  logic [14:0]    user_min_y,
  input  logic [14:0]    user_max_x,
  input  logic [14:0]    user_max_y,
  input  logic           user_scissor_enable,
  input  vsg_pkg::cfg_t  cfg,
  output logic           out_valid,
  output vsg_pkg::div_t  out_d
);
  import vsg_pkg::*;

  // stage a
  logic a_v;
  logic signed [VW-1:0] ax0, ay0, ax1, ay1;
  logic a_full;
  logic [14:0] a_umx0, a_umy0, a_umx1, a_umy1;
  logic a_use;

  // stage b
  logic b_v;
  logic signed [VW-1:0] vx0, vy0, vx1, vy1;
  logic [14:0] b_umx0, b_umy0, b_umx1, b_umy1;
  logic b_use;

  logic signed [VW-1:0] sxe, sye, txe, tye;
  logic signed [VW-1:0] ex0, ey0, ex1, ey1;

  assign sxe = {{(VW-24){scale_x[23]}}, scale_x};
  assign sye = {{(VW-24){scale_y[23]}}, scale_y};
  assign txe = {{(VW-24){translate_x[23]}}, translate_x};
  assign tye = {{(VW-24){translate_y[23]}}, translate_y};
  assign ex0 = txe - sxe;
  assign ey0 = tye - sye;
  assign ex1 = txe + sxe;
  assign ey1 = tye + sye;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_full <= (ex0 == -ONE) && (ey0 == -ONE) && (ex1 == ONE) && (ey1 == ONE);
      ax0 <= (ex0 > ex1) ? ex1 : ex0;
      ax1 <= (ex0 > ex1) ? ex0 : ex1;
      ay0 <= (ey0 > ey1) ? ey1 : ey0;
      ay1 <= (ey0 > ey1) ? ey0 : ey1;
      a_umx0 <= user_min_x;
      a_umy0 <= user_min_y;
      a_umx1 <= user_max_x;
      a_umy1 <= user_max_y;
      a_use <= user_scissor_enable;
    end
  end

  logic [15:0] maxs;
  assign maxs = (cfg.gen != GEN_OLD) ? MAXS_NEW : MAXS_OLD;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (a_full) begin
        vx0 <= '0;
        vy0 <= '0;
        vx1 <= VW'(maxs);
        vy1 <= VW'(maxs);
      end else begin
        vx0 <= trunc_q(ax0);
        vy0 <= trunc_q(ay0);
        vx1 <= ceil_q(ax1);
        vy1 <= ceil_q(ay1);
      end
      b_umx0 <= a_umx0;
      b_umy0 <= a_umy0;
      b_umx1 <= a_umx1;
      b_umy1 <= a_umy1;
      b_use <= a_use;
    end
  end

  function automatic logic [15:0] clampv(input logic signed [VW-1:0] v, input logic [15:0] m);
    if (v[VW-1]) return '0;
    if (v > signed'(VW'(m))) return m;
    return v[15:0];
  endfunction

  // stage c combinational
  logic [15:0] fx0, fy0, fx1, fy1;
  logic signed [VW:0] wxs, wys, sumx, sumy;
  logic [VW:0] absx, absy;
  logic signed [VW+2:0] numx, numy;
  logic [16:0] two_r;
  div_t c_d;

  always_comb begin
    if (cfg.bypass) begin
      fx0 = '0;
      fy0 = '0;
      fx1 = maxs;
      fy1 = maxs;
    end else begin
      fx0 = clampv(vx0, maxs);
      fy0 = clampv(vy0, maxs);
      fx1 = clampv(vx1, maxs);
      fy1 = clampv(vy1, maxs);
    end
    if (b_use) begin
      if ({1'b0, b_umx0} > fx0) fx0 = {1'b0, b_umx0};
      if ({1'b0, b_umy0} > fy0) fy0 = {1'b0, b_umy0};
      if ({1'b0, b_umx1} < fx1) fx1 = {1'b0, b_umx1};
      if ({1'b0, b_umy1} < fy1) fy1 = {1'b0, b_umy1};
    end
    if (cfg.gen != GEN_OLD) begin
      if (fx1 == 16'd0) fx0 = 16'd1;
      if (fy1 == 16'd0) fy0 = 16'd1;
      if (cfg.gen != GEN_SECOND && fx1 == 16'd1 && fy1 == 16'd1) fx1 = 16'd2;
    end

    two_r = (cfg.gen != GEN_OLD) ? TWO_R_NEW : TWO_R_OLD;
    wxs = {vx1[VW-1], vx1} - {vx0[VW-1], vx0};
    wys = {vy1[VW-1], vy1} - {vy0[VW-1], vy0};
    if (wxs <= 0) wxs = (VW+1)'(1);
    if (wys <= 0) wys = (VW+1)'(1);
    sumx = {vx1[VW-1], vx1} + {vx0[VW-1], vx0};
    sumy = {vy1[VW-1], vy1} + {vy0[VW-1], vy0};
    absx = sumx[VW] ? (VW+1)'(-sumx) : sumx;
    absy = sumy[VW] ? (VW+1)'(-sumy) : sumy;
    numx = signed'((VW+3)'(two_r)) - signed'((VW+3)'(absx));
    numy = signed'((VW+3)'(two_r)) - signed'((VW+3)'(absy));

    c_d.wx = wxs[DW-1:0];
    c_d.wy = wys[DW-1:0];
    c_d.rgx = '0;
    c_d.rgy = '0;
    c_d.rdx = '0;
    c_d.rdy = '0;
    c_d.qgx = numx[VW+2] ? '0 : {numx[15:0], 16'd0};
    c_d.qgy = numy[VW+2] ? '0 : {numy[15:0], 16'd0};
    c_d.qdx = {cfg.disc, 8'd0};
    c_d.qdy = {cfg.disc, 8'd0};
    c_d.side.tl = {1'b1, fy0[14:0], 1'b0, fx0[14:0]};
    c_d.side.br = {fy1[14:0], 1'b0, fx1[14:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d <= c_d;
    end
  end

endmodule

// ===== hw/rtl/vsg_div_stage.sv =====
// one divider stage: a few quotient bits for each of the four lanes
module vsg_div_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  vsg_pkg::div_t in_d,
  output logic          out_valid,
  output vsg_pkg::div_t out_d
);
  import vsg_pkg::*;

  function automatic logic [RW+QW-1:0] steps(input logic [RW-1:0] r, input logic [QW-1:0] q,
                                             input logic [DW-1:0] d);
    logic [RW-1:0] rr;
    logic [QW-1:0] qq;
    rr = r;
    qq = q;
    for (int i = 0; i < DIV_BITS; i++) begin
      rr = {rr[RW-2:0], qq[QW-1]};
      qq = {qq[QW-2:0], 1'b0};
      if (rr >= {1'b0, d}) begin
        rr = rr - {1'b0, d};
        qq[0] = 1'b1;
      end
    end
    return {rr, qq};
  endfunction

  div_t d_next;

  always_comb begin
    d_next = in_d;
    {d_next.rgx, d_next.qgx} = steps(in_d.rgx, in_d.qgx, in_d.wx);
    {d_next.rgy, d_next.qgy} = steps(in_d.rgy, in_d.qgy, in_d.wy);
    {d_next.rdx, d_next.qdx} = steps(in_d.rdx, in_d.qdx, in_d.wx);
    {d_next.rdy, d_next.qdy} = steps(in_d.rdy, in_d.qdy, in_d.wy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d <= d_next;
    end
  end

endmodule

// ===== hw/rtl/viewport_scissor_guardband.sv =====
// top level of the viewport scissor and guard band block
//
//  channel  | direction | contents
//  s_axis   | in        | viewport scale/translate and user scissor per transfer
//  m_axis   | out       | packed scissor words and guard/discard factors
//  apb      | in        | chip_generation, clip_bypass, discard_distance
//
// one transfer in and one out per cycle while m_axis is not stalled; 3 front stages,
// 8 divider stages of 4 quotient bits and 1 output stage
// rst clears all valid bits and sets chip_generation 1, others 0
// a stall on m_axis holds every stage; s_tready follows it
module viewport_scissor_guardband (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // scale_x, scale_y, translate_x, translate_y, user_min_x, user_min_y,
  // user_max_x, user_max_y, zero pad
  input  logic [159:0] s_tdata,
  // user_scissor_enable
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // top_left_word, bottom_right_word, guard_x, guard_y, margin_x, margin_y, zero pad
  output logic [191:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import vsg_pkg::*;

  cfg_t cfg;
  logic en;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gen <= GEN_SECOND;
      cfg.bypass <= 1'b0;
      cfg.disc <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_GEN: cfg.gen <= pwdata[1:0];
        REG_BYPASS: cfg.bypass <= pwdata[0];
        REG_DISCARD: cfg.disc <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GEN: prdata = {30'd0, cfg.gen};
      REG_BYPASS: prdata = {31'd0, cfg.bypass};
      REG_DISCARD: prdata = {8'd0, cfg.disc};
      default: prdata = '0;
    endcase
  end

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  logic v_chain [0:DIV_STAGES];
  div_t d_chain [0:DIV_STAGES];

  vsg_front u_front (
    .clk                 (clk),
    .rst                 (rst),
    .en                  (en),
    .in_valid            (s_tvalid),
    .scale_x             (s_tdata[23:0]),
    .scale_y             (s_tdata[47:24]),
    .translate_x         (s_tdata[71:48]),
    .translate_y         (s_tdata[95:72]),
    .user_min_x          (s_tdata[110:96]),
    .user_min_y          (s_tdata[125:111]),
    .user_max_x          (s_tdata[140:126]),
    .user_max_y          (s_tdata[155:141]),
    .user_scissor_enable (s_tuser),
    .cfg                 (cfg),
    .out_valid           (v_chain[0]),
    .out_d               (d_chain[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    vsg_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (v_chain[g]),
      .in_d      (d_chain[g]),
      .out_valid (v_chain[g+1]),
      .out_d     (d_chain[g+1])
    );
  end

  div_t fin;
  logic [32:0] dsum_x, dsum_y;
  logic [31:0] dsc_x, dsc_y;

  assign fin = d_chain[DIV_STAGES];

  always_comb begin
    dsum_x = {1'b0, fin.qdx} + 33'd65536;
    dsum_y = {1'b0, fin.qdy} + 33'd65536;
    dsc_x = dsum_x[32] ? 32'hFFFF_FFFF : dsum_x[31:0];
    dsc_y = dsum_y[32] ? 32'hFFFF_FFFF : dsum_y[31:0];
    if (dsc_x > fin.qgx) dsc_x = fin.qgx;
    if (dsc_y > fin.qgy) dsc_y = fin.qgy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= v_chain[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {1'b0, dsc_y, dsc_x, fin.qgy, fin.qgx, fin.side.br, fin.side.tl};
    end
  end

endmodule

// ===== hw/rtl/vsg_checker.sv =====
// port-level checks for the viewport scissor and guard band block
`include "viewport_scissor_guardband_defines.svh"

module vsg_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [191:0] m_tdata
);

  `VSG_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output changed while stalled")
  `VSG_ASSERT_IMPL(a_ready, clk, rst, m_tvalid && !m_tready, !s_tready, "input taken while output stalled")
  `VSG_ASSERT_IMPL(a_marks, clk, rst, m_tvalid, m_tdata[31] && !m_tdata[15] && !m_tdata[47], "bad packed scissor words")
  `VSG_ASSERT_IMPL(a_disc, clk, rst, m_tvalid, (m_tdata[158:127] <= m_tdata[94:63]) && (m_tdata[190:159] <= m_tdata[126:95]), "discard exceeds guard")

endmodule

bind viewport_scissor_guardband vsg_checker u_vsg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
